@@ sv/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared widths, operation codes and sequencer state encodings.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int CoordW  = 32;
  localparam int DiffMax = 3;
  localparam int WorkW   = CoordW + DiffMax;
  localparam int OutW    = 48;
  localparam int PcW     = 5;
  localparam int IdxW    = 4;
  localparam int ParamW  = 17;
  localparam int OrdW    = 2;

  localparam logic signed [63:0] OutMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OutMin = -64'sh0000_8000_0000_0000;

  typedef enum logic [3:0] {
    OP_COPY  = 4'b0001,
    OP_DIFF  = 4'b0010,
    OP_LERP  = 4'b0100,
    OP_SCALE = 4'b1000
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_RD0  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PASS_COPY = 2'd0,
    PASS_DIFF = 2'd1,
    PASS_LERP = 2'd2
  } pass_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    alu_op_t op;
  } alu_ctl_t;

endpackage

@@ sv/bce_alu.sv @@
// ----------------------------------------------------------------------------
// Bezier evaluator arithmetic unit
// Shared subtract / multiply / round unit: copy, difference, linear step, scaling with saturation.
// ----------------------------------------------------------------------------
module bce_alu #(
  parameter int FRAC_BITS = 16,
  parameter int SCALE_W   = 15
) (
  input  bce_pkg::alu_ctl_t                    ctl,
  input  logic signed [bce_pkg::WorkW-1:0]     a,
  input  logic signed [bce_pkg::WorkW-1:0]     b,
  input  logic        [FRAC_BITS:0]            t,
  input  logic        [SCALE_W-1:0]            scale,
  output logic signed [bce_pkg::WorkW-1:0]     res_w,
  output logic signed [bce_pkg::OutW-1:0]      res_o
);
  import bce_pkg::*;

  localparam int TW  = FRAC_BITS + 1;
  localparam int MBW = ((TW > SCALE_W) ? TW : SCALE_W) + 1;
  localparam int MAW = WorkW + 1;
  localparam int PW  = MAW + MBW;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [MAW-1:0] diff;
  logic signed [MAW-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  rnd;
  logic signed [63:0]    pw;

  assign diff = MAW'(b) - MAW'(a);
  assign ma   = (ctl.op == OP_SCALE) ? MAW'(a) : diff;
  assign mb   = (ctl.op == OP_SCALE) ? signed'(MBW'(scale)) : signed'(MBW'(t));
  assign prod = ma * mb;
  // round half up, then floor via arithmetic shift
  assign rnd  = prod + Half;
  assign pw   = 64'(prod);

  always_comb begin
    unique case (ctl.op)
      OP_COPY:  res_w = b;
      OP_DIFF:  res_w = WorkW'(diff);
      OP_LERP:  res_w = a + WorkW'(rnd >>> FRAC_BITS);
      OP_SCALE: res_w = a;
      default:  res_w = b;
    endcase
  end

  always_comb begin
    if (pw > OutMax) begin
      res_o = OutW'(OutMax);
    end else if (pw < OutMin) begin
      res_o = OutW'(OutMin);
    end else begin
      res_o = OutW'(pw);
    end
  end

endmodule

@@ sv/bezier_curve_evaluator_top.sv @@
// ----------------------------------------------------------------------------
// Bezier curve evaluator
// Load control points, then evaluate the curve or a derivative at t.
// ----------------------------------------------------------------------------
// A load request writes its point into the point store when accepted. An
// evaluate request runs each axis in turn through one shared
// subtract-multiply-round unit: a copy pass over the n points, d difference
// passes, then de Casteljau passes of shrinking length, one element a cycle.
// Each pass ends with a drain of the last read and a turnaround, and each axis
// ends with a read state and a state for the final scale and saturate. The
// work memory's single read port sets the pace. The input is not ready while
// a request is in work or its result waits to be taken.
module bezier_curve_evaluator_top #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [bce_pkg::PcW-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic        [bce_pkg::IdxW-1:0]      point_index,
  input  logic signed [bce_pkg::CoordW-1:0]    point_x,
  input  logic signed [bce_pkg::CoordW-1:0]    point_y,
  input  logic signed [bce_pkg::CoordW-1:0]    point_z,
  input  logic        [bce_pkg::ParamW-1:0]    param_t,
  input  logic        [bce_pkg::OrdW-1:0]      derivative_order,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bce_pkg::OutW-1:0]      out_x,
  output logic signed [bce_pkg::OutW-1:0]      out_y,
  output logic signed [bce_pkg::OutW-1:0]      out_z,
  output logic                                 valid_res
);
  import bce_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int SCW = 3 * NW;
  localparam int TW  = FRAC_BITS + 1;
  localparam logic [TW-1:0] TOne = TW'(2 ** FRAC_BITS);

  // control points and work memory
  logic signed [CoordW-1:0] stx [MAX_POINTS];
  logic signed [CoordW-1:0] sty [MAX_POINTS];
  logic signed [CoordW-1:0] stz [MAX_POINTS];
  logic signed [WorkW-1:0]  wk  [MAX_POINTS];
  logic signed [CoordW-1:0] stx_q, sty_q, stz_q;
  logic signed [WorkW-1:0]  wk_q;

  state_t              state;
  pass_t               pass;
  axis_t               axis;
  logic [PcW-1:0]      pc;
  logic [NW-1:0]       n_r;
  logic [OrdW-1:0]     d_r;
  logic [OrdW-1:0]     dleft;
  logic [TW-1:0]       t_r;
  logic [NW-1:0]       len;
  logic [NW-1:0]       idx;
  logic                rd_vld;
  logic [AW-1:0]       rd_idx;
  logic signed [WorkW-1:0] prev;
  logic [SCW-1:0]      scale;
  logic signed [OutW-1:0] res_x, res_y, res_z;
  logic                vres;

  logic                acc_in, acc_load, acc_eval;
  logic [NW-1:0]       n_c;
  logic [TW-1:0]       t_c;
  logic                issue, pass_done;
  logic [NW-1:0]       cnt;
  logic [AW-1:0]       rd_addr;
  logic signed [CoordW-1:0] st_sel;
  logic signed [WorkW-1:0]  cur;
  logic                wk_we;
  logic [AW-1:0]       wk_waddr;
  alu_ctl_t            alu_ctl;
  logic signed [WorkW-1:0] alu_w;
  logic signed [OutW-1:0]  alu_o;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_x     = res_x;
  assign out_y     = res_y;
  assign out_z     = res_z;
  assign valid_res = vres;

  assign acc_in   = in_valid && in_ready;
  assign acc_load = acc_in && !kind;
  assign acc_eval = acc_in && kind;

  always_comb begin
    if (pc == '0) begin
      n_c = NW'(1);
    end else if (int'(pc) > MAX_POINTS) begin
      n_c = NW'(MAX_POINTS);
    end else begin
      n_c = NW'(pc);
    end
    if (int'(param_t) > 2 ** FRAC_BITS) begin
      t_c = TOne;
    end else begin
      t_c = TW'(param_t);
    end
  end

  assign issue     = (state == S_RUN) && (idx < len);
  assign pass_done = (state == S_RUN) && (idx == len) && !rd_vld;
  assign cnt       = (pass == PASS_COPY) ? n_r : len - NW'(1);
  assign rd_addr   = (state == S_RUN) ? idx[AW-1:0] : '0;

  always_comb begin
    unique case (axis)
      AXIS_X:  st_sel = stx_q;
      AXIS_Y:  st_sel = sty_q;
      AXIS_Z:  st_sel = stz_q;
      default: st_sel = stx_q;
    endcase
  end

  assign cur = (pass == PASS_COPY) ? WorkW'(st_sel) : wk_q;

  always_comb begin
    if (state == S_MUL) begin
      alu_ctl.op = OP_SCALE;
    end else begin
      unique case (pass)
        PASS_COPY: alu_ctl.op = OP_COPY;
        PASS_DIFF: alu_ctl.op = OP_DIFF;
        PASS_LERP: alu_ctl.op = OP_LERP;
        default:   alu_ctl.op = OP_COPY;
      endcase
    end
  end

  assign wk_we    = rd_vld && ((pass == PASS_COPY) || (rd_idx != '0));
  assign wk_waddr = (pass == PASS_COPY) ? rd_idx : rd_idx - AW'(1);

  bce_alu #(
    .FRAC_BITS (FRAC_BITS),
    .SCALE_W   (SCW)
  ) u_alu (
    .ctl   (alu_ctl),
    .a     ((state == S_MUL) ? wk_q : prev),
    .b     (cur),
    .t     (t_r),
    .scale (scale),
    .res_w (alu_w),
    .res_o (alu_o)
  );

  always_ff @(posedge clk) begin
    if (acc_load && (int'(point_index) < MAX_POINTS)) begin
      stx[AW'(point_index)] <= point_x;
      sty[AW'(point_index)] <= point_y;
      stz[AW'(point_index)] <= point_z;
    end
    stx_q <= stx[rd_addr];
    sty_q <= sty[rd_addr];
    stz_q <= stz[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk[wk_waddr] <= alu_w;
    end
    wk_q <= wk[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev <= cur;
    end
    if (state == S_MUL) begin
      unique case (axis)
        AXIS_X:  res_x <= alu_o;
        AXIS_Y:  res_y <= alu_o;
        AXIS_Z:  res_z <= alu_o;
        default: res_x <= alu_o;
      endcase
    end else if (acc_eval && (int'(n_c) <= int'(derivative_order))) begin
      res_x <= '0;
      res_y <= '0;
      res_z <= '0;
    end
    if (acc_eval) begin
      n_r <= n_c;
      d_r <= derivative_order;
      t_r <= t_c;
    end
    rd_idx <= idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= PcW'(4);
      pass   <= PASS_COPY;
      axis   <= AXIS_X;
      dleft  <= '0;
      len    <= '0;
      idx    <= '0;
      rd_vld <= 1'b0;
      scale  <= '0;
      vres   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pc <= cfg_data;
      end
      rd_vld <= issue;
      if (issue) begin
        idx <= idx + NW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (acc_eval) begin
            if (int'(n_c) <= int'(derivative_order)) begin
              vres  <= 1'b0;
              state <= S_OUT;
            end else begin
              vres  <= 1'b1;
              axis  <= AXIS_X;
              pass  <= PASS_COPY;
              len   <= n_c;
              idx   <= '0;
              dleft <= derivative_order;
              scale <= SCW'(1);
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (pass_done) begin
            idx <= '0;
            if (pass == PASS_DIFF) begin
              scale <= SCW'(scale * cnt);
            end
            // pick the next pass from what is left
            if ((pass != PASS_LERP) && (dleft != '0)) begin
              pass  <= PASS_DIFF;
              len   <= cnt;
              dleft <= dleft - OrdW'(1);
            end else if (cnt >= NW'(2)) begin
              pass <= PASS_LERP;
              len  <= cnt;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state <= S_MUL;
        end
        S_MUL: begin
          if (axis == AXIS_Z) begin
            state <= S_OUT;
          end else begin
            axis  <= axis_t'(axis + 2'd1);
            pass  <= PASS_COPY;
            len   <= n_r;
            idx   <= '0;
            dleft <= d_r;
            scale <= SCW'(1);
            state <= S_RUN;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind) |=> !in_ready)
    else $error("evaluate request did not start work");

  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (int'(rd_idx) < int'(len)))
    else $error("read beyond pass length");

  a_axis: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (axis != 2'd3))
    else $error("axis counter out of range");

endmodule

@@ tb/sv/tb_bezier_curve_evaluator_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bezier curve evaluator testbench
// Loads control points, evaluates the curve and its derivatives at fixed and random t
// and point counts, and checks every result against a local fixed-point
// de Casteljau predictor.
// ----------------------------------------------------------------------------
module tb_bezier_curve_evaluator_top;
  import bce_pkg::*;

  localparam int NPTS      = 16;
  localparam int FRAC      = 16;
  localparam int WDOG_MAX  = 20000;
  localparam bit KIND_LOAD = 1'b0;
  localparam bit KIND_EVAL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [IdxW-1:0]   idx;
    logic [31:0]       px, py, pz;
    logic [ParamW-1:0] t;
    logic [OrdW-1:0]   ord;
  } req_t;

  typedef struct packed {
    logic [OutW-1:0] x, y, z;
    logic            ok;
  } curve_res_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, in_valid = 0, out_ready = 0;
  logic cfg_ready, in_ready, out_valid, valid_res;
  logic [PcW-1:0] cfg_data = '0;
  logic kind = 0;
  logic [IdxW-1:0] point_index = '0;
  logic signed [CoordW-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [ParamW-1:0] param_t = '0;
  logic [OrdW-1:0] derivative_order = '0;
  logic signed [OutW-1:0] out_x, out_y, out_z;

  bezier_curve_evaluator_top i_dut (.*);

  req_t       pending_reqs[$];
  curve_res_t expected_pts[$];
  longint     pts_x[NPTS], pts_y[NPTS], pts_z[NPTS];
  int         cur_count;
  int         errors = 0;
  int         in_gap = 0, out_gap = 0, idle_cycles = 0;
  bit         cfg_pending = 0;
  logic [PcW-1:0] cfg_value;

  initial forever #4 clk = ~clk;

  function automatic longint lerp_round(longint a, longint b, longint t);
    return a + (((b - a) * t + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic logic [OutW-1:0] axis_value(longint p[NPTS], int n, int d,
                                                 longint t, longint scale);
    longint w[NPTS];
    longint v;
    int m;
    for (int k = 0; k < n; k++) w[k] = p[k];
    for (int r = 0; r < d; r++)
      for (int k = 0; k + 1 + r < n; k++) w[k] = w[k+1] - w[k];
    m = n - 1 - d;
    for (int r = 1; r <= m; r++)
      for (int k = 0; k + r <= m; k++) w[k] = lerp_round(w[k], w[k+1], t);
    v = w[0] * scale;
    if (v > OutMax) v = OutMax;
    if (v < OutMin) v = OutMin;
    return v[OutW-1:0];
  endfunction

  function automatic void predict_curve(req_t r);
    curve_res_t e;
    int n, d;
    longint t, scale;
    if (r.kind == KIND_LOAD) begin
      pts_x[r.idx] = longint'($signed(r.px));
      pts_y[r.idx] = longint'($signed(r.py));
      pts_z[r.idx] = longint'($signed(r.pz));
      return;
    end
    n = cur_count == 0 ? 1 : (cur_count > NPTS ? NPTS : cur_count);
    d = int'(r.ord);
    t = longint'(r.t);
    if (t > (64'sd1 <<< FRAC)) t = 64'sd1 <<< FRAC;
    e = '0;
    if (n > d) begin
      scale = 1;
      for (int j = 1; j <= d; j++) scale *= (n - j);
      e.x = axis_value(pts_x, n, d, t, scale);
      e.y = axis_value(pts_y, n, d, t, scale);
      e.z = axis_value(pts_z, n, d, t, scale);
      e.ok = 1;
    end
    expected_pts.push_back(e);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_curve(pending_reqs.pop_front());
        in_gap <= $urandom_range(0, 19);
        in_valid <= 0;
      end else if (!in_valid && in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (!in_valid && pending_reqs.size() > 0 && !cfg_pending) begin
        in_valid <= 1;
        kind <= pending_reqs[0].kind;
        point_index <= pending_reqs[0].idx;
        point_x <= pending_reqs[0].px;
        point_y <= pending_reqs[0].py;
        point_z <= pending_reqs[0].pz;
        param_t <= pending_reqs[0].t;
        derivative_order <= pending_reqs[0].ord;
      end
      if (cfg_valid && cfg_ready) begin
        cur_count = int'(cfg_data);
        cfg_valid <= 0;
        cfg_pending <= 0;
      end else if (cfg_pending && !cfg_valid) begin
        cfg_valid <= 1;
        cfg_data <= cfg_value;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h v=%b", $time,
                   out_x, out_y, out_z, valid_res);
          errors++;
        end else begin
          curve_res_t e;
          e = expected_pts.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_z !== e.z || valid_res !== e.ok) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h v=%b actual x=%h y=%h z=%h v=%b",
                     $time, e.x, e.y, e.z, e.ok, out_x, out_y, out_z, valid_res);
            errors++;
          end
        end
        out_gap <= $urandom_range(0, 19);
        out_ready <= 0;
      end else if (!out_ready) begin
        if (out_gap > 0) out_gap <= out_gap - 1;
        else out_ready <= 1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("[bezier_curve_evaluator_top] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_load(int idx, logic [31:0] x, y, z);
    req_t r;
    r = '0;
    r.kind = KIND_LOAD; r.idx = IdxW'(idx); r.px = x; r.py = y; r.pz = z;
    r.t = ParamW'($urandom); r.ord = OrdW'($urandom);
    return r;
  endfunction

  function automatic req_t make_eval(int t, int ord);
    req_t r;
    r = '0;
    r.kind = KIND_EVAL; r.idx = IdxW'($urandom); r.px = $urandom; r.py = $urandom;
    r.pz = $urandom; r.t = ParamW'(t); r.ord = OrdW'(ord);
    return r;
  endfunction

  task automatic drain_and_config(int value);
    while (pending_reqs.size() > 0 || in_valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_value = PcW'(value);
    cfg_pending = 1;
    while (cfg_pending) @(posedge clk);
  endtask

  function automatic int rand_t();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  initial begin
    cur_count = 4;
    repeat (5) @(posedge clk);
    rst <= 0;
    // load all slots first so no evaluate reads an unwritten point
    pending_reqs.push_back(make_load(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    pending_reqs.push_back(make_load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    for (int k = 2; k < NPTS; k++)
      pending_reqs.push_back(make_load(k, rand_coord(), rand_coord(), rand_coord()));
    for (int o = 0; o < 4; o++) begin
      pending_reqs.push_back(make_eval(0, o));
      pending_reqs.push_back(make_eval(65536, o));
    end
    pending_reqs.push_back(make_eval(131071, 1));
    drain_and_config(1);
    for (int o = 0; o < 4; o++) pending_reqs.push_back(make_eval(32768, o));
    drain_and_config(16);
    for (int o = 0; o < 4; o++) pending_reqs.push_back(make_eval(rand_t(), o));
    drain_and_config(0);
    pending_reqs.push_back(make_eval(1000, 0));
    pending_reqs.push_back(make_eval(1000, 1));
    drain_and_config(31);
    pending_reqs.push_back(make_eval(40000, 3));
    for (int ph = 0; ph < 8; ph++) begin
      // mostly small point counts keep the run short
      drain_and_config(ph == 7 ? 16 : $urandom_range(1, 6));
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 2) == 0)
          pending_reqs.push_back(make_load($urandom_range(0, 15), rand_coord(),
                                           rand_coord(), rand_coord()));
        else
          pending_reqs.push_back(make_eval(rand_t(), $urandom_range(0, 3)));
      end
    end
    while (pending_reqs.size() > 0 || in_valid || expected_pts.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("[bezier_curve_evaluator_top] OK");
    else $display("[bezier_curve_evaluator_top] ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/bce_pkg.sv
sv/bce_alu.sv
sv/bezier_curve_evaluator_top.sv
tb/sv/tb_bezier_curve_evaluator_top.sv
